>>> hdl/arh_pkg.sv
// Package for the auto-range histogram: constants, payload word types, controller commands.
// No dependencies.
package arh_pkg;

   localparam int MAX_SAMPLES_DEF = 4096;
   localparam int MAX_BARS_DEF    = 64;
   localparam int MIN_SAMPLES     = 12;
   localparam int MIN_BARS        = 4;
   localparam logic [31:0] ZERO_SPAN_QUARTER = 32'd1639;
   localparam logic [12:0] COUNT_SAT = 13'd8191;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FEW      = 2'd1;
   localparam logic [1:0] ST_BADRANGE = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic [1:0] CSR_BAR_COUNT  = 2'd0;
   localparam logic [1:0] CSR_AUTO_RANGE = 2'd1;
   localparam logic [1:0] CSR_RANGE_LOW  = 2'd2;
   localparam logic [1:0] CSR_RANGE_HIGH = 2'd3;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               is_last;
   } req_word_type;

   typedef struct packed {
      logic [5:0]         bar_index;
      logic [12:0]        bar_height;
      logic [12:0]        max_height;
      logic signed [39:0] lower_edge;
      logic signed [39:0] upper_edge;
      logic [1:0]         status;
      logic               last_bar;
   } rsp_word_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // store accepted sample
      logic range_set;  // latch range, start divider, zero clear pointer
      logic div_step;   // one divider iteration
      logic bin_start;  // zero read pointer and max
      logic bin_step;   // issue one store read / count one sample
      logic clr_step;   // clear one bar count
      logic emit_start; // zero emit pointer
      logic emit_load;  // load output register with current bar
      logic emit_err;   // load output register with error word
      logic clear_run;  // reset run state
   } ctrl_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic       few;
      logic       bad_range;
      logic       div_done;
      logic       bin_done;
      logic       clr_done;
      logic       emit_final;
      logic [1:0] err_code;
   } dp_stat_type;

endpackage

>>> hdl/arh_datapath.sv
// Datapath of the auto-range histogram: sample store, run statistics, range,
// quarter-width divider, bin index divider, bar count array, output register. Uses arh_pkg.
module arh_datapath
   import arh_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int MAX_BARS    = MAX_BARS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  logic [6:0]   bar_count_cfg,
   input  logic         auto_range_cfg,
   input  logic [31:0]  range_low_cfg,
   input  logic [31:0]  range_high_cfg,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output rsp_word_type rsp_word
);
   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int TW = AW + 1;
   localparam int BW = $clog2(MAX_BARS);
   localparam int NBW = BW + 1;
   localparam int QW = 34;  // divider width for span / (4*bars)
   localparam int DW = 41;  // width of (v-lo)*bars numerator

   // sample store
   logic [31:0] store_mem [MAX_SAMPLES];
   logic [31:0] rd_data_ff;
   logic [TW-1:0] total_ff, total_in;
   logic signed [31:0] min_ff, max_ff, min_in, max_in;
   logic ovf_ff, ovf_in;

   always_ff @(posedge clock) begin
      if (cmd.load && total_ff < TW'(MAX_SAMPLES))
         store_mem[total_ff[AW-1:0]] <= req_word.sample;
   end

   // run statistics
   always_comb begin
      total_in = total_ff;
      min_in = min_ff;
      max_in = max_ff;
      ovf_in = ovf_ff;
      if (cmd.clear_run) begin
         total_in = '0;
         min_in = 32'sh7fffffff;
         max_in = 32'sh80000000;
         ovf_in = 1'b0;
      end else if (cmd.load) begin
         if (total_ff < TW'(MAX_SAMPLES)) begin
            total_in = total_ff + 1'b1;
            if (req_word.sample < min_ff) min_in = req_word.sample;
            if (req_word.sample > max_ff) max_in = req_word.sample;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         min_ff <= 32'sh7fffffff;
         max_ff <= 32'sh80000000;
         ovf_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         min_ff <= min_in;
         max_ff <= max_in;
         ovf_ff <= ovf_in;
      end
   end

   // saturated bar count
   logic [NBW-1:0] bars;
   always_comb begin
      if (bar_count_cfg < 7'(MIN_BARS)) bars = NBW'(MIN_BARS);
      else if (bar_count_cfg > 7'(MAX_BARS)) bars = NBW'(MAX_BARS);
      else bars = bar_count_cfg[NBW-1:0];
   end

   logic signed [39:0] lo_ff, hi_ff;
   logic [NBW-1:0] bars_ff;
   logic [32:0] span_ff;
   logic [32:0] wid_ff;

   // restoring divider for the quarter width: span / (4*bars), rounded up
   logic [QW-1:0] qrem_ff, qquo_ff;
   logic [5:0] qcnt_ff;
   logic [QW-1:0] qrem_sh;
   logic [QW-1:0] qdiv;
   assign qdiv = QW'(bars_ff) << 2;
   assign qrem_sh = {qrem_ff[QW-2:0], span_ff[6'd32 - qcnt_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         qcnt_ff <= '0;
      end else if (cmd.range_set) begin
         qcnt_ff <= '0;
      end else if (cmd.div_step && qcnt_ff != 6'd33) begin
         qcnt_ff <= qcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.range_set) begin
         bars_ff <= bars;
         span_ff <= 33'(max_ff) - 33'(min_ff);
         qrem_ff <= '0;
         qquo_ff <= '0;
         if (auto_range_cfg) begin
            lo_ff <= 40'(min_ff);
            hi_ff <= 40'(max_ff);
         end else begin
            lo_ff <= 40'(signed'(range_low_cfg));
            hi_ff <= 40'(signed'(range_high_cfg));
         end
      end else if (cmd.div_step && qcnt_ff != 6'd33) begin
         if (qrem_sh >= qdiv) begin
            qrem_ff <= qrem_sh - qdiv;
            qquo_ff <= {qquo_ff[QW-2:0], 1'b1};
         end else begin
            qrem_ff <= qrem_sh;
            qquo_ff <= {qquo_ff[QW-2:0], 1'b0};
         end
      end else if (cmd.bin_start) begin
         if (auto_range_cfg) begin
            if (span_ff == '0) begin
               lo_ff <= lo_ff - 40'(ZERO_SPAN_QUARTER);
               hi_ff <= hi_ff + 40'(ZERO_SPAN_QUARTER);
            end else begin
               lo_ff <= lo_ff - 40'(qquo_ff + QW'(qrem_ff != '0));
               hi_ff <= hi_ff + 40'(qquo_ff + QW'(qrem_ff != '0));
            end
         end
      end
   end

   // range width, registered after the range is final
   always_ff @(posedge clock) begin
      wid_ff <= 33'(hi_ff - lo_ff);
   end

   // binning: read pointer, pipelined read, serial bin divider
   logic [TW-1:0] rptr_ff;
   logic          rd_vld_ff;
   logic [5:0]    bcnt_ff;
   logic          bbusy_ff;
   logic [DW-1:0] bnum_ff;
   logic [33:0]   brem_ff;
   logic [BW:0]   bquo_ff;
   logic [33:0]   brem_sh;
   logic          in_rng;
   logic signed [40:0] voff;

   assign voff = 41'(signed'(rd_data_ff)) - 41'(lo_ff);
   assign in_rng = (40'(signed'(rd_data_ff)) >= lo_ff) && (40'(signed'(rd_data_ff)) < hi_ff);
   assign brem_sh = {brem_ff[32:0], bnum_ff[DW-1]};

   always_ff @(posedge clock) begin
      if (cmd.bin_step && !rd_vld_ff && !bbusy_ff)
         rd_data_ff <= store_mem[rptr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rptr_ff <= '0;
         rd_vld_ff <= 1'b0;
         bbusy_ff <= 1'b0;
         bcnt_ff <= '0;
      end else if (cmd.bin_start) begin
         rptr_ff <= '0;
         rd_vld_ff <= 1'b0;
         bbusy_ff <= 1'b0;
      end else if (cmd.bin_step) begin
         if (bbusy_ff) begin
            bcnt_ff <= bcnt_ff + 1'b1;
            if (bcnt_ff == 6'(DW - 1)) bbusy_ff <= 1'b0;
         end else if (rd_vld_ff) begin
            rd_vld_ff <= 1'b0;
            if (in_rng) begin
               bbusy_ff <= 1'b1;
               bcnt_ff <= '0;
            end
         end else if (rptr_ff != total_ff) begin
            rd_vld_ff <= 1'b1;
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
   end

   // long division (v-lo)*bars / width, one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.bin_step && !bbusy_ff && rd_vld_ff && in_rng) begin
         bnum_ff <= DW'(unsigned'(voff[32:0]) * bars_ff);
         brem_ff <= '0;
         bquo_ff <= '0;
      end else if (cmd.bin_step && bbusy_ff) begin
         bnum_ff <= {bnum_ff[DW-2:0], 1'b0};
         if (brem_sh >= 34'(wid_ff)) begin
            brem_ff <= brem_sh - 34'(wid_ff);
            bquo_ff <= {bquo_ff[BW-1:0], 1'b1};
         end else begin
            brem_ff <= brem_sh;
            bquo_ff <= {bquo_ff[BW-1:0], 1'b0};
         end
      end
   end

   logic bin_fin_ff;
   always_ff @(posedge clock) begin
      if (reset) bin_fin_ff <= 1'b0;
      else bin_fin_ff <= cmd.bin_step && bbusy_ff && bcnt_ff == 6'(DW - 1);
   end

   // bar counts: one array, read with registered data, written one bar a cycle
   logic [12:0]  cnt_mem [MAX_BARS];
   logic [12:0]  cnt_rd_ff;
   logic [12:0]  cnt_q_ff;
   logic [12:0]  cnt_inc;
   logic         binc_ff;
   logic [BW:0]  cptr_ff;
   logic [BW:0]  eptr_ff, eptr_in;
   logic [12:0]  maxh_ff;

   assign cnt_inc = (cnt_rd_ff == COUNT_SAT) ? cnt_rd_ff : cnt_rd_ff + 13'd1;

   // read the bar a finished division points at; bump it in the next cycle
   always_ff @(posedge clock) begin
      if (bin_fin_ff) cnt_rd_ff <= cnt_mem[bquo_ff[BW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) binc_ff <= 1'b0;
      else binc_ff <= bin_fin_ff && bquo_ff < (BW+1)'(bars_ff);
   end

   // clear pointer walks the bars in use while the quarter width divides
   always_ff @(posedge clock) begin
      if (reset || cmd.range_set) cptr_ff <= '0;
      else if (cmd.clr_step && cptr_ff != (BW+1)'(bars_ff)) cptr_ff <= cptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step && cptr_ff != (BW+1)'(bars_ff))
         cnt_mem[cptr_ff[BW-1:0]] <= '0;
      else if (binc_ff)
         cnt_mem[bquo_ff[BW-1:0]] <= cnt_inc;
   end

   // largest count, tracked as bars are bumped
   always_ff @(posedge clock) begin
      if (cmd.bin_start) maxh_ff <= '0;
      else if (binc_ff && cnt_inc > maxh_ff) maxh_ff <= cnt_inc;
   end

   // emit pointer; count read in the cycle before the output load
   always_comb begin
      eptr_in = eptr_ff;
      if (cmd.emit_start) eptr_in = '0;
      else if (cmd.emit_load) eptr_in = eptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) eptr_ff <= '0;
      else eptr_ff <= eptr_in;
   end

   always_ff @(posedge clock) begin
      cnt_q_ff <= cnt_mem[eptr_in[BW-1:0]];
   end

   // output register
   rsp_word_type err_word;
   always_comb begin
      err_word = '0;
      err_word.status = stat.err_code;
      err_word.last_bar = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_err) begin
         rsp_word <= err_word;
      end else if (cmd.emit_load) begin
         rsp_word.bar_index <= 6'(eptr_ff);
         rsp_word.bar_height <= cnt_q_ff;
         rsp_word.max_height <= maxh_ff;
         rsp_word.lower_edge <= lo_ff;
         rsp_word.upper_edge <= hi_ff;
         rsp_word.status <= ovf_ff ? ST_OVERFLOW : ST_OK;
         rsp_word.last_bar <= (eptr_ff == (BW+1)'(bars_ff) - 1'b1);
      end
   end

   // status to controller
   always_comb begin
      stat.few = total_ff < TW'(MIN_SAMPLES);
      stat.bad_range = !auto_range_cfg &&
                       (signed'(range_low_cfg) >= signed'(range_high_cfg));
      stat.err_code = stat.few ? ST_FEW : ST_BADRANGE;
      stat.div_done = qcnt_ff == 6'd33;
      stat.bin_done = rptr_ff == total_ff && !rd_vld_ff && !bbusy_ff && !bin_fin_ff
                      && !binc_ff;
      stat.clr_done = cptr_ff == (BW+1)'(bars_ff);
      stat.emit_final = eptr_ff == (BW+1)'(bars_ff);
   end
endmodule

>>> hdl/arh_controller.sv
// Controller of the auto-range histogram: load, range and count clear, binning, emit.
// Uses arh_pkg.
module arh_controller
   import arh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);
   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_BIN   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       vld_ff, vld_in;
   logic       take;

   assign req_ready = state_ff == S_LOAD && !vld_ff;
   assign rsp_valid = vld_ff;
   assign take = !vld_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      vld_in = vld_ff && !rsp_ready;
      cmd = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               if (req_last) state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.few || stat.bad_range) begin
               cmd.emit_err = 1'b1;
               cmd.clear_run = 1'b1;
               vld_in = 1'b1;
               state_in = S_LOAD;
            end else begin
               cmd.range_set = 1'b1;
               state_in = S_DIV;
            end
         end
         // quarter width divides while the bar counts clear
         S_DIV: begin
            cmd.div_step = 1'b1;
            cmd.clr_step = 1'b1;
            if (stat.div_done && stat.clr_done) begin
               cmd.bin_start = 1'b1;
               state_in = S_BIN;
            end
         end
         S_BIN: begin
            cmd.bin_step = 1'b1;
            if (stat.bin_done) begin
               cmd.emit_start = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.emit_final) begin
               state_in = S_DRAIN;
            end else if (take) begin
               cmd.emit_load = 1'b1;
               vld_in = 1'b1;
            end
         end
         S_DRAIN: begin
            cmd.clear_run = 1'b1;
            state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
   end
endmodule

>>> hdl/auto_range_histogram.sv
// Top level of the auto-range histogram: config registers, controller, datapath.
// Uses arh_pkg, arh_controller, arh_datapath.
//
//  channel | ports                          | words
//  req     | req_valid/req_ready/req_word   | one sample, is_last closes a set
//  rsp     | rsp_valid/rsp_ready/rsp_word   | one per bar, or one error word
//  csr     | csr_write/csr_index/csr_data   | register writes, no read-back
//
// Samples load at one per cycle while req_ready is high. After the last sample
// come a check state, then quarter-width division with the bar counts cleared
// alongside, then binning with a serial bin divider for each sample in range;
// then one word per bar while rsp_ready holds, and a drain state closes the set.
// Reset is synchronous; the store is not cleared. A stalled rsp holds its word;
// req_ready stays low from the last sample until the final word of the set is
// taken.
module auto_range_histogram
   import arh_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int MAX_BARS    = MAX_BARS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   logic [6:0]  bar_count_ff;
   logic        auto_range_ff;
   logic [31:0] range_low_ff, range_high_ff;
   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bar_count_ff <= 7'd16;
         auto_range_ff <= 1'b1;
         range_low_ff <= '0;
         range_high_ff <= 32'd65536;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BAR_COUNT:  bar_count_ff <= csr_data[6:0];
            CSR_AUTO_RANGE: auto_range_ff <= csr_data[0];
            CSR_RANGE_LOW:  range_low_ff <= csr_data;
            CSR_RANGE_HIGH: range_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   arh_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_last(req_word.is_last), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .stat(stat), .cmd(cmd)
   );

   arh_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_BARS(MAX_BARS)) u_dp (
      .clock(clock), .reset(reset), .req_word(req_word),
      .bar_count_cfg(bar_count_ff), .auto_range_cfg(auto_range_ff),
      .range_low_cfg(range_low_ff), .range_high_cfg(range_high_ff),
      .cmd(cmd), .stat(stat), .rsp_word(rsp_word)
   );
endmodule

>>> bench/tb_top.sv
// Self-checking bench for auto_range_histogram: feeds sample sets, predicts each bar word.
// Depends on arh_pkg and the auto_range_histogram RTL.
`timescale 1ns / 100ps

module tb_top;
   import arh_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int IDLE_WAIT   = 60;
   localparam int STALL_LIMIT = 800000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write = 1'b0;
   logic [1:0]   csr_index = CSR_BAR_COUNT;
   logic [31:0]  csr_data = '0;

   auto_range_histogram uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the register file
   logic [6:0]  bars_reg  = 7'd16;
   logic        auto_reg  = 1'b1;
   logic [31:0] limit_lo  = 32'd0;
   logic [31:0] limit_hi  = 32'd65536;

   // shadow of the run state
   logic [31:0] set_store [STORE_DEPTH];
   int          set_total = 0;
   longint      set_min = 64'sd2147483647;
   longint      set_max = -64'sd2147483648;
   bit          set_overflow = 0;

   rsp_word_type bar_expect[$];
   req_word_type sample_queue[$];
   int  words_queued = 0;
   int  words_taken = 0;
   int  mismatches = 0;
   bit  tx_eager = 0;
   bit  rx_eager = 0;
   int  hold_asked = 0;

   function automatic void clear_set();
      set_total = 0;
      set_min = 64'sd2147483647;
      set_max = -64'sd2147483648;
      set_overflow = 0;
   endfunction

   // one accepted sample word; queues the histogram once the set closes
   function automatic void predict_histogram(req_word_type w);
      longint x, lo, hi, q, span, dv, width, v, b;
      int bars, k, maxh;
      int counts[64];
      rsp_word_type r;
      x = longint'($signed(w.sample));
      if (set_total < STORE_DEPTH) begin
         set_store[set_total] = w.sample;
         set_total++;
         if (x < set_min) set_min = x;
         if (x > set_max) set_max = x;
      end else begin
         set_overflow = 1;
      end
      if (!w.is_last) return;
      bars = int'(bars_reg);
      if (bars < MIN_BARS) bars = MIN_BARS;
      if (bars > MAX_BARS_DEF) bars = MAX_BARS_DEF;
      r = '0;
      r.last_bar = 1'b1;
      if (set_total < MIN_SAMPLES) begin
         r.status = ST_FEW;
         bar_expect = {bar_expect, r};
         clear_set();
         return;
      end
      if (auto_reg) begin
         span = set_max - set_min;
         dv = 4 * bars;
         q = (span == 0) ? longint'(ZERO_SPAN_QUARTER) : (span + dv - 1) / dv;
         lo = set_min - q;
         hi = set_max + q;
      end else begin
         lo = longint'($signed(limit_lo));
         hi = longint'($signed(limit_hi));
         if (lo >= hi) begin
            r.status = ST_BADRANGE;
            bar_expect = {bar_expect, r};
            clear_set();
            return;
         end
      end
      for (k = 0; k < 64; k++) counts[k] = 0;
      width = hi - lo;
      for (k = 0; k < set_total; k++) begin
         v = longint'($signed(set_store[k]));
         if (v >= lo && v < hi) begin
            b = ((v - lo) * bars) / width;
            if (b < bars) counts[b]++;
         end
      end
      maxh = 0;
      for (k = 0; k < bars; k++) if (counts[k] > maxh) maxh = counts[k];
      for (k = 0; k < bars; k++) begin
         r.bar_index  = k[5:0];
         r.bar_height = (counts[k] > 8191) ? COUNT_SAT : counts[k][12:0];
         r.max_height = (maxh > 8191) ? COUNT_SAT : maxh[12:0];
         r.lower_edge = lo[39:0];
         r.upper_edge = hi[39:0];
         r.status     = set_overflow ? ST_OVERFLOW : ST_OK;
         r.last_bar   = (k == bars - 1);
         bar_expect = {bar_expect, r};
      end
      clear_set();
   endfunction

   // sender: one word at a time from the queue, random gap per word
   int tx_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap <= 0;
      end else if (req_valid && !req_ready) begin
         // hold the word until taken
      end else if (tx_gap > 0) begin
         tx_gap <= tx_gap - 1;
         req_valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
         req_word <= sample_queue.pop_front();
         req_valid <= 1'b1;
         tx_gap <= tx_eager ? 0 : $urandom_range(0, 19);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: random stall per word, plus a long hold once a word is waiting
   int rx_gap = 0;
   int hold_left = 0;
   int hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_done != hold_asked && rsp_valid) begin
         hold_done <= hold_asked;
         hold_left <= 500;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (rsp_valid && rsp_ready) begin
         rx_gap <= rx_eager ? 0 : $urandom_range(0, 19);
         rsp_ready <= rx_eager;
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_ready <= (rx_gap == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: predict on accepted samples, check accepted bar words
   int stall_count = 0;
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_histogram(req_word);
            words_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (bar_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected bar word: idx %0d h %0d st %0d",
                           rsp_word.bar_index, rsp_word.bar_height, rsp_word.status);
            end else begin
               e = bar_expect.pop_front();
               if (rsp_word.bar_index !== e.bar_index ||
                   rsp_word.bar_height !== e.bar_height ||
                   rsp_word.max_height !== e.max_height ||
                   rsp_word.lower_edge !== e.lower_edge ||
                   rsp_word.upper_edge !== e.upper_edge ||
                   rsp_word.status !== e.status ||
                   rsp_word.last_bar !== e.last_bar) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch exp: idx %0d h %0d mh %0d lo %h hi %h st %0d last %0d",
                              e.bar_index, e.bar_height, e.max_height, e.lower_edge,
                              e.upper_edge, e.status, e.last_bar);
                     $display("         got: idx %0d h %0d mh %0d lo %h hi %h st %0d last %0d",
                              rsp_word.bar_index, rsp_word.bar_height,
                              rsp_word.max_height, rsp_word.lower_edge,
                              rsp_word.upper_edge, rsp_word.status, rsp_word.last_bar);
                  end
               end
            end
         end
         // watchdog on cycles with no word moving on either side
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_count = 0;
         else stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // write all four registers; only called while the block is idle
   task automatic program_regs(logic [31:0] bars, logic [31:0] auto,
                               logic [31:0] lo, logic [31:0] hi);
      @(posedge clock);
      csr_write <= 1'b1; csr_index <= CSR_BAR_COUNT; csr_data <= bars;
      bars_reg = bars[6:0];
      @(posedge clock);
      csr_index <= CSR_AUTO_RANGE; csr_data <= auto;
      auto_reg = auto[0];
      @(posedge clock);
      csr_index <= CSR_RANGE_LOW; csr_data <= lo;
      limit_lo = lo;
      @(posedge clock);
      csr_index <= CSR_RANGE_HIGH; csr_data <= hi;
      limit_hi = hi;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic push_word(logic [31:0] s, bit last);
      req_word_type w;
      w.sample = s;
      w.is_last = last;
      sample_queue = {sample_queue, w};
      words_queued++;
   endtask

   // style 0: full range, 1: tight cluster, 2: mostly inside limits, 3: constant
   task automatic queue_set(int n, int style);
      int i;
      logic [31:0] base, s;
      longint width;
      base = $urandom;
      width = longint'($signed(limit_hi)) - longint'($signed(limit_lo));
      for (i = 0; i < n; i++) begin
         case (style)
            0: s = $urandom;
            1: s = base + $urandom_range(0, 4095);
            2: s = ($urandom_range(0, 9) < 8 && width > 0) ?
                   limit_lo + 32'(longint'($urandom) % width) : $urandom;
            default: s = base;
         endcase
         push_word(s, i == n - 1);
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (words_taken != words_queued || bar_expect.size() != 0);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   initial begin
      int ph, sets, j, sty, n, random_words;
      logic [31:0] a, b;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset config, extremes of the sample field
      push_word(32'h8000_0000, 0);
      push_word(32'h7FFF_FFFF, 0);
      push_word(32'h0000_0000, 0);
      push_word(32'hFFFF_FFFF, 0);
      queue_set(8, 1);
      drain();
      // too few samples, then a lone last word
      queue_set(11, 0);
      push_word(32'h1234_5678, 1);
      // zero span
      queue_set(12, 3);
      drain();
      // limit mode, equal and crossed limits
      program_regs(32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000);
      queue_set(12, 2);
      drain();
      program_regs(32'd127, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_set(12, 2);
      drain();
      // limit mode at both ends of the bar count, edge samples
      program_regs(32'd3, 32'd0, 32'hFFFF_0000, 32'h0002_0000);
      push_word(32'hFFFF_0000, 0);
      push_word(32'h0001_FFFF, 0);
      push_word(32'h0002_0000, 0);
      push_word(32'hFFFE_FFFF, 0);
      queue_set(10, 2);
      drain();
      program_regs(32'hFFFF_FFC1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_set(14, 0);
      drain();

      // random phases; the first one holds the receiver off for a long stretch
      random_words = 0;
      ph = 0;
      while (random_words < 160) begin
         a = $urandom;
         b = $urandom;
         if ($urandom_range(0, 3) == 0) b = a;
         program_regs($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(4, 64),
                      $urandom_range(0, 1), $signed(a) < $signed(b) ? a : b,
                      $signed(a) < $signed(b) ? b : a);
         tx_eager = ($urandom_range(0, 3) == 0);
         rx_eager = ($urandom_range(0, 3) == 0);
         if (ph == 0) hold_asked++;
         sets = (ph == 0) ? 3 : $urandom_range(1, 3);
         for (j = 0; j < sets; j++) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : $urandom_range(12, 30);
            sty = $urandom_range(0, 3);
            if (!auto_reg && sty != 3) sty = 2;
            queue_set(n, sty);
            random_words += n;
         end
         drain();
         ph++;
      end

      if (mismatches == 0 && bar_expect.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
